/* design/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the proxy client handshake checker.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam logic [2:0] PH_WAIT_SOCKET = 3'd0;
	localparam logic [2:0] PH_REPLY       = 3'd1;
	localparam logic [2:0] PH_AUTH        = 3'd2;
	localparam logic [2:0] PH_TUNNEL      = 3'd3;
	localparam logic [2:0] PH_CONNECTED   = 3'd4;
	localparam logic [2:0] PH_FAILED      = 3'd5;

	localparam logic [2:0] EV_WAIT       = 3'd0;
	localparam logic [2:0] EV_V4_CONNECT = 3'd1;
	localparam logic [2:0] EV_METHOD_REQ = 3'd2;
	localparam logic [2:0] EV_USER_PASS  = 3'd3;
	localparam logic [2:0] EV_V5_CONNECT = 3'd4;
	localparam logic [2:0] EV_CONNECTED  = 3'd5;
	localparam logic [2:0] EV_DATA       = 3'd6;
	localparam logic [2:0] EV_ERROR      = 3'd7;

	localparam logic [1:0] ERR_BAD_REPLY  = 2'd0;
	localparam logic [1:0] ERR_BAD_STATE  = 2'd1;
	localparam logic [1:0] ERR_ASSOC_DATA = 2'd2;

	localparam logic [1:0] REG_PROXY_KIND       = 2'd0;
	localparam logic [1:0] REG_AUTH_OFFERED     = 2'd1;
	localparam logic [1:0] REG_ASSOCIATION_LINK = 2'd2;

	localparam logic [7:0] V4_VERSION     = 8'h00;
	localparam logic [7:0] V4_GRANTED     = 8'h90;
	localparam logic [7:0] V5_VERSION     = 8'h05;
	localparam logic [7:0] METHOD_NONE    = 8'h00;
	localparam logic [7:0] METHOD_USERPASS = 8'h02;
	localparam logic [7:0] ATYP_IPV4      = 8'h01;
	localparam logic [7:0] ATYP_IPV6      = 8'h04;
	localparam logic [7:0] AUTH_VERSION   = 8'h01;
	localparam logic [7:0] STATUS_OK      = 8'h00;

	localparam logic [4:0] LEN_V4_REPLY   = 5'd8;
	localparam logic [4:0] LEN_SHORT      = 5'd2;
	localparam logic [4:0] LEN_CONN_HEAD  = 5'd4;
	localparam logic [4:0] LEN_CONN_V4    = 5'd10;
	localparam logic [4:0] LEN_CONN_V6    = 5'd22;
	localparam logic [4:0] COUNT_MAX      = 5'd31;

	typedef struct packed {
		logic       proxy_kind;
		logic       auth_offered;
		logic       association_link;
	} scc_cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] byte_count;
		logic       version_ok;
		logic       status_ok;
		logic       method_is_userpass;
		logic       address_is_v6;
		logic       address_type_ok;
	} scc_state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
		logic       chunk_end;
	} scc_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_out;
		logic [1:0] method_count;
		logic [1:0] error_kind;
	} scc_result_t;

endpackage

/* design/scc_step.sv */
// ----------------------------------------------------------------------------
// scc_step
// Per-item handshake logic: captures reply bytes, judges a reply at chunk
// end and gives the next state and the result of one item.
// ----------------------------------------------------------------------------
module scc_step import scc_pkg::*; (
	input  scc_cfg_t    cfg,
	input  scc_state_t  st,
	input  scc_item_t   item,
	output scc_state_t  st_next,
	output scc_result_t res
);

	scc_state_t cap;
	scc_state_t cleared;
	logic [2:0] ev;
	logic [1:0] err;
	logic [4:0] need;
	logic [7:0] b;
	logic       idx0;
	logic       idx1;
	logic       idx3;

	assign b    = item.rx_byte;
	assign idx0 = (st.byte_count == 5'd0);
	assign idx1 = (st.byte_count == 5'd1);
	assign idx3 = (st.byte_count == 5'd3);

	// reply byte capture
	always_comb begin
		cap = st;
		if (st.phase == PH_REPLY) begin
			if (!cfg.proxy_kind) begin
				if (idx0) cap.version_ok = (b == V4_VERSION);
				if (idx1) cap.status_ok = (b == V4_GRANTED);
			end else begin
				if (idx0) cap.version_ok = (b == V5_VERSION);
				if (idx1) begin
					cap.status_ok = (b == METHOD_NONE) || (b == METHOD_USERPASS);
					cap.method_is_userpass = (b == METHOD_USERPASS);
				end
			end
		end else if (st.phase == PH_AUTH) begin
			if (idx0) cap.version_ok = (b == AUTH_VERSION);
			if (idx1) cap.status_ok = (b == STATUS_OK);
		end else begin
			if (idx0) cap.version_ok = (b == V5_VERSION);
			if (idx1) cap.status_ok = (b == STATUS_OK);
			if (idx3) begin
				cap.address_type_ok = (b == ATYP_IPV4) || (b == ATYP_IPV6);
				cap.address_is_v6 = (b == ATYP_IPV6);
			end
		end
		if (st.byte_count < COUNT_MAX) cap.byte_count = st.byte_count + 5'd1;
	end

	always_comb begin
		cleared = '0;
		st_next = st;
		res = '0;
		ev = EV_WAIT;
		err = ERR_BAD_REPLY;
		need = LEN_SHORT;
		if (!item.mode) begin
			if (st.phase == PH_WAIT_SOCKET) begin
				st_next = cleared;
				st_next.phase = PH_REPLY;
				if (!cfg.proxy_kind) begin
					ev = EV_V4_CONNECT;
				end else begin
					ev = EV_METHOD_REQ;
					res.method_count = cfg.auth_offered ? 2'd2 : 2'd1;
				end
			end else begin
				ev = EV_ERROR;
				err = ERR_BAD_STATE;
			end
		end else begin
			case (st.phase)
				PH_CONNECTED: begin
					if (cfg.association_link) begin
						ev = EV_ERROR;
						err = ERR_ASSOC_DATA;
					end else begin
						ev = EV_DATA;
						res.data_out = b;
					end
				end
				PH_REPLY, PH_AUTH, PH_TUNNEL: begin
					st_next = cap;
					if (item.chunk_end) begin
						if (st.phase == PH_TUNNEL) begin
							need = cap.address_is_v6 ? LEN_CONN_V6 : LEN_CONN_V4;
							if (cap.byte_count < LEN_CONN_HEAD) begin
								ev = EV_WAIT;
							end else if (!cap.version_ok || !cap.status_ok ||
								!cap.address_type_ok) begin
								ev = EV_ERROR;
							end else if (cap.byte_count < need) begin
								ev = EV_WAIT;
							end else if (cap.byte_count > need) begin
								ev = EV_ERROR;
							end else begin
								ev = EV_CONNECTED;
								st_next = cleared;
								st_next.phase = PH_CONNECTED;
							end
						end else begin
							if (st.phase == PH_REPLY && !cfg.proxy_kind) need = LEN_V4_REPLY;
							if (cap.byte_count > need) begin
								ev = EV_ERROR;
							end else if (cap.byte_count < need) begin
								ev = EV_WAIT;
							end else if (!cap.version_ok || !cap.status_ok) begin
								ev = EV_ERROR;
							end else if (st.phase == PH_REPLY && !cfg.proxy_kind) begin
								ev = EV_CONNECTED;
								st_next = cleared;
								st_next.phase = PH_CONNECTED;
							end else if (st.phase == PH_REPLY && cap.method_is_userpass) begin
								if (!cfg.auth_offered) begin
									ev = EV_ERROR;
								end else begin
									ev = EV_USER_PASS;
									st_next = cleared;
									st_next.phase = PH_AUTH;
								end
							end else begin
								ev = EV_V5_CONNECT;
								st_next = cleared;
								st_next.phase = PH_TUNNEL;
							end
						end
					end
				end
				default: begin
					ev = EV_ERROR;
					err = ERR_BAD_STATE;
				end
			endcase
		end
		if (ev == EV_ERROR) begin
			st_next.phase = PH_FAILED;
			res.error_kind = err;
		end
		res.event_res = ev;
	end

endmodule

/* design/socks_client_handshake_checker.sv */
// ----------------------------------------------------------------------------
// socks_client_handshake_checker
// Client side of a SOCKS4 / SOCKS5 proxy handshake with reply checking and
// pass-through of bytes once the tunnel is up.
// ----------------------------------------------------------------------------
// Takes one item per clock while results are taken, and gives exactly one
// result per item. An accepted item waits in the input register, where the
// step logic updates the handshake state; the new state and the result are
// registered when the result register is empty or being read. The state
// update is a loop through the step logic, which sets the rate of one item per
// cycle; the result register lets a new item in while a result waits to be
// taken. There is no clearing pass after reset. Config writes are taken at once.
module socks_client_handshake_checker import scc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // mode
	input  logic        s_axis_tlast,   // chunk_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // data_out, method_count, error_kind, zero pad
	output logic [2:0]  m_axis_tuser,   // event_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

	scc_cfg_t    cfg_q;
	scc_state_t  state_q;
	scc_state_t  state_next;
	scc_item_t   item_s1;
	logic        valid_s1;
	scc_result_t res;
	scc_result_t res_s2;
	logic        valid_s2;
	logic        advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{proxy_kind: 1'b1, auth_offered: 1'b0, association_link: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROXY_KIND:       cfg_q.proxy_kind <= cfg_data;
				REG_AUTH_OFFERED:     cfg_q.auth_offered <= cfg_data;
				REG_ASSOCIATION_LINK: cfg_q.association_link <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{mode: s_axis_tuser, rx_byte: s_axis_tdata, chunk_end: s_axis_tlast};
		end
	end

	scc_step u_step (
		.cfg     (cfg_q),
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.event_res;
	assign m_axis_tdata  = {4'd0, res_s2.error_kind, res_s2.method_count, res_s2.data_out};

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.phase == PH_FAILED |=> m_axis_tuser == EV_ERROR)
		else $error("item after failure did not give an error");

	a_method_only_on_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |-> m_axis_tuser == EV_METHOD_REQ)
		else $error("method count outside method request");

	a_data_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 |-> m_axis_tuser == EV_DATA)
		else $error("data byte outside data event");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

/* test/scc_reply_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scc_reply_checker
// Watches the item, result and register channels of the proxy handshake
// checker, keeps its own copy of the handshake state and registers, works
// out the result of every item transfer and compares each result transfer
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module scc_reply_checker import scc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // mode
	input  logic        s_axis_tlast,   // chunk_end
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // data_out, method_count, error_kind, zero pad
	input  logic [2:0]  m_axis_tuser,   // event_res
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);

	scc_cfg_t    regs;
	scc_state_t  hs;
	scc_result_t expected_q[$];
	scc_result_t got;
	scc_result_t want;
	scc_item_t   item;

	function automatic void clear_reply();
		hs.byte_count         = '0;
		hs.version_ok         = 1'b0;
		hs.status_ok          = 1'b0;
		hs.method_is_userpass = 1'b0;
		hs.address_is_v6      = 1'b0;
		hs.address_type_ok    = 1'b0;
	endfunction

	function automatic void capture_byte(logic [7:0] b);
		logic [4:0] idx;
		idx = hs.byte_count;
		case (hs.phase)
			PH_REPLY: begin
				if (!regs.proxy_kind) begin
					if (idx == 5'd0) hs.version_ok = (b == V4_VERSION);
					if (idx == 5'd1) hs.status_ok = (b == V4_GRANTED);
				end else begin
					if (idx == 5'd0) hs.version_ok = (b == V5_VERSION);
					if (idx == 5'd1) begin
						hs.status_ok = (b == METHOD_NONE) || (b == METHOD_USERPASS);
						hs.method_is_userpass = (b == METHOD_USERPASS);
					end
				end
			end
			PH_AUTH: begin
				if (idx == 5'd0) hs.version_ok = (b == AUTH_VERSION);
				if (idx == 5'd1) hs.status_ok = (b == STATUS_OK);
			end
			default: begin
				if (idx == 5'd0) hs.version_ok = (b == V5_VERSION);
				if (idx == 5'd1) hs.status_ok = (b == STATUS_OK);
				if (idx == 5'd3) begin
					hs.address_type_ok = (b == ATYP_IPV4) || (b == ATYP_IPV6);
					hs.address_is_v6 = (b == ATYP_IPV6);
				end
			end
		endcase
		if (hs.byte_count != COUNT_MAX) hs.byte_count = hs.byte_count + 5'd1;
	endfunction

	// judge the gathered reply at a chunk end
	function automatic logic [2:0] judge_reply();
		logic [4:0] need;
		if (hs.phase == PH_TUNNEL) begin
			if (hs.byte_count < LEN_CONN_HEAD) return EV_WAIT;
			if (!hs.version_ok || !hs.status_ok || !hs.address_type_ok) return EV_ERROR;
			need = hs.address_is_v6 ? LEN_CONN_V6 : LEN_CONN_V4;
			if (hs.byte_count < need) return EV_WAIT;
			if (hs.byte_count > need) return EV_ERROR;
			hs.phase = PH_CONNECTED;
			clear_reply();
			return EV_CONNECTED;
		end
		need = (hs.phase == PH_REPLY && !regs.proxy_kind) ? LEN_V4_REPLY : LEN_SHORT;
		if (hs.byte_count > need) return EV_ERROR;
		if (hs.byte_count < need) return EV_WAIT;
		if (!hs.version_ok || !hs.status_ok) return EV_ERROR;
		if (hs.phase == PH_REPLY) begin
			if (!regs.proxy_kind) begin
				hs.phase = PH_CONNECTED;
				clear_reply();
				return EV_CONNECTED;
			end
			if (hs.method_is_userpass) begin
				if (!regs.auth_offered) return EV_ERROR;
				hs.phase = PH_AUTH;
				clear_reply();
				return EV_USER_PASS;
			end
		end
		hs.phase = PH_TUNNEL;
		clear_reply();
		return EV_V5_CONNECT;
	endfunction

	function automatic scc_result_t predict_step(scc_item_t it);
		scc_result_t r;
		logic [2:0]  ev;
		logic [1:0]  err;
		r   = '0;
		ev  = EV_WAIT;
		err = ERR_BAD_REPLY;
		if (!it.mode) begin
			if (hs.phase == PH_WAIT_SOCKET) begin
				clear_reply();
				hs.phase = PH_REPLY;
				if (!regs.proxy_kind) begin
					ev = EV_V4_CONNECT;
				end else begin
					ev = EV_METHOD_REQ;
					r.method_count = regs.auth_offered ? 2'd2 : 2'd1;
				end
			end else begin
				ev  = EV_ERROR;
				err = ERR_BAD_STATE;
			end
		end else if (hs.phase == PH_CONNECTED) begin
			if (regs.association_link) begin
				ev  = EV_ERROR;
				err = ERR_ASSOC_DATA;
			end else begin
				ev = EV_DATA;
				r.data_out = it.rx_byte;
			end
		end else if (hs.phase == PH_REPLY || hs.phase == PH_AUTH || hs.phase == PH_TUNNEL) begin
			capture_byte(it.rx_byte);
			if (it.chunk_end) ev = judge_reply();
		end else begin
			ev  = EV_ERROR;
			err = ERR_BAD_STATE;
		end
		if (ev == EV_ERROR) begin
			hs.phase = PH_FAILED;
			r.error_kind = err;
		end
		r.event_res = ev;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got_v, want_v);
		mismatches = mismatches + 1;
	endtask

	task automatic check_field(input string what, input int got_v, input int want_v);
		if (got_v != want_v) report_mismatch(what, got_v, want_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.proxy_kind       = 1'b1;
			regs.auth_offered     = 1'b0;
			regs.association_link = 1'b0;
			hs                    = '0;
			hs.phase              = PH_WAIT_SOCKET;
			expected_q.delete();
			mismatches   = 0;
			results_seen = 0;
			pending     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.event_res    = m_axis_tuser;
				got.data_out     = m_axis_tdata[7:0];
				got.method_count = m_axis_tdata[9:8];
				got.error_kind   = m_axis_tdata[11:10];
				results_seen = results_seen + 1;
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing outstanding, event",
						int'(got.event_res), -1);
				end else begin
					want = expected_q.pop_front();
					check_field("event_res", int'(got.event_res), int'(want.event_res));
					check_field("data_out", int'(got.data_out), int'(want.data_out));
					check_field("method_count", int'(got.method_count),
						int'(want.method_count));
					check_field("error_kind", int'(got.error_kind), int'(want.error_kind));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROXY_KIND:       regs.proxy_kind = cfg_data;
					REG_AUTH_OFFERED:     regs.auth_offered = cfg_data;
					REG_ASSOCIATION_LINK: regs.association_link = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item.mode      = s_axis_tuser;
				item.rx_byte   = s_axis_tdata;
				item.chunk_end = s_axis_tlast;
				expected_q.push_back(predict_step(item));
			end
			pending <= expected_q.size();
		end
	end

endmodule

/* test/tb_socks_client_handshake_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_socks_client_handshake_checker
// Drives one proxy handshake per run, its path and any broken step picked at
// random, then a long stream of pass-through bytes under changing registers,
// and finally data on an association link and noise in the failed state.
// Both stream sides idle in random bursts; a separate checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_socks_client_handshake_checker;
	import scc_pkg::*;

	localparam int         LONG_HOLD   = 300;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // rx_byte
	logic        s_axis_tuser;   // mode
	logic        s_axis_tlast;   // chunk_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // data_out, method_count, error_kind, zero pad
	logic [2:0]  m_axis_tuser;   // event_res
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic        cfg_data;

	int          mismatches;
	int          pending;
	int          results_seen;
	int          items_sent;
	bit          idle_on;
	bit          hold_req;
	logic [7:0]  reply_bytes[$];
	logic        use_v5;
	logic        use_auth;
	logic        pick_userpass;
	logic        use_v6;
	bit          fault_on;
	int          fault_stage;
	int          fault_how;

	socks_client_handshake_checker DUT (.*);

	scc_reply_checker u_checker (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_item(input logic m, input logic [7:0] b, input logic e);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= b;
		s_axis_tlast  <= e;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_random(input int n, input bit any_mode);
		repeat (n)
			send_item(any_mode ? 1'($urandom_range(0, 1)) : 1'b1, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// break the reply planned for this step, if this is the chosen one
	task automatic maybe_break(input int stage);
		int k;
		if (fault_on && fault_stage == stage) begin
			if (fault_how == 0) begin
				k = $urandom_range(0, 1);
				reply_bytes[k] = reply_bytes[k] ^ 8'($urandom_range(1, 255));
			end else begin
				reply_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// chunk ends fall at random, always on the last byte
	task automatic send_reply();
		for (int i = 0; i < reply_bytes.size(); i++)
			send_item(1'b1, reply_bytes[i],
				(i == reply_bytes.size() - 1) || ($urandom_range(0, 3) == 0));
		wait_drained();
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_PROXY_KIND;
		cfg_data      <= 1'b0;
		items_sent  = 0;
		idle_on     = 1'b1;
		hold_req    = 1'b0;
		use_v5      = 1'($urandom_range(0, 1));
		use_auth    = 1'($urandom_range(0, 1));
		fault_on    = ($urandom_range(0, 3) == 0);
		fault_stage = $urandom_range(0, 3);
		fault_how   = $urandom_range(0, 1);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_PROXY_KIND, use_v5);
		write_reg(REG_AUTH_OFFERED, use_auth);
		write_reg(REG_ASSOCIATION_LINK, 1'b0);

		// byte before the socket is up
		if (fault_on && fault_stage == 0)
			send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		wait_drained();

		if (!use_v5) begin
			reply_bytes = {V4_VERSION, V4_GRANTED};
			repeat (6) reply_bytes.push_back(8'($urandom_range(0, 255)));
			maybe_break(1);
			send_reply();
		end else begin
			pick_userpass = use_auth && ($urandom_range(0, 1) == 1);
			reply_bytes = {V5_VERSION, pick_userpass ? METHOD_USERPASS : METHOD_NONE};
			maybe_break(1);
			send_reply();
			if (pick_userpass) begin
				reply_bytes = {AUTH_VERSION, STATUS_OK};
				maybe_break(2);
				send_reply();
			end
			use_v6 = 1'($urandom_range(0, 1));
			reply_bytes = {V5_VERSION, STATUS_OK, 8'($urandom_range(0, 255)),
				use_v6 ? ATYP_IPV6 : ATYP_IPV4};
			repeat (use_v6 ? 18 : 6) reply_bytes.push_back(8'($urandom_range(0, 255)));
			maybe_break(3);
			send_reply();
		end

		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b1, 8'hFF, 1'b1);
		send_item(1'b1, 8'hA5, 1'b0);
		send_item(1'b1, 8'h5A, 1'b1);

		// sink holds off while bytes keep coming
		hold_req = 1'b1;
		send_random(40, 1'b0);
		wait_drained();

		for (int seg = 0; seg < 5; seg++) begin
			write_reg(REG_PROXY_KIND, seg[0]);
			write_reg(REG_AUTH_OFFERED, 1'($urandom_range(0, 1)));
			send_random(270, 1'b0);
			wait_drained();
		end

		write_reg(REG_ASSOCIATION_LINK, 1'b1);
		send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_random(150, 1'b1);
		idle_on = 1'b0;
		send_random(150, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("run covered %0d item transfers and %0d checked results",
			items_sent, results_seen);
		$display("handshake: proxy kind %0d, credentials %0d, broken step %0d",
			use_v5, use_auth, fault_on ? fault_stage : -1);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
design/scc_pkg.sv
design/scc_step.sv
design/socks_client_handshake_checker.sv
test/scc_reply_checker.sv
test/tb_socks_client_handshake_checker.sv
